>>> rtl/decimal_display_digit_formatter_assert.svh
// Assertion macros used by the decimal display digit formatter RTL.
`ifndef DECIMAL_DISPLAY_DIGIT_FORMATTER_ASSERT_SVH
`define DECIMAL_DISPLAY_DIGIT_FORMATTER_ASSERT_SVH
`ifndef SYNTH
// Check a property on every rising edge outside reset.
`define DDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ddf assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define DDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ddf assertion failed");
`else
`define DDF_ASSERT(lbl, clk, rstn, prop)
`define DDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/ddf_pkg.sv
// Shared types and constants of the decimal display digit formatter.
`default_nettype none
package ddf_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int VALUE_W = 32;
  localparam int MAG_W = VALUE_W - 1;
  localparam int POS_W = 4;
  localparam int CODE_W = 4;

  localparam logic [CODE_W-1:0] CODE_ZERO = 4'd0;
  localparam logic [CODE_W-1:0] CODE_ONE = 4'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
  localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

  // floor(n / 10) == (n * RECIP) >> RECIP_SHIFT for every n below 2^32
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_W = MAG_W + RECIP_W;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_POS,
    KIND_ZERO,
    KIND_NEG
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> rtl/ddf_front.sv
// Front end: takes a value beat, classifies its sign and queues it.
`default_nettype none
module ddf_front (
  input  logic                          start,
  input  logic [ddf_pkg::VALUE_W-1:0]   in_value,
  input  ddf_pkg::q_stat_t              q_stat,
  output logic                          busy,
  output logic                          push,
  output ddf_pkg::item_t                push_item
);

  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  always_comb begin
    push_item.mag = in_value[ddf_pkg::MAG_W-1:0];
    if (in_value[ddf_pkg::VALUE_W-1]) begin
      push_item.kind = ddf_pkg::KIND_NEG;
    end else if (in_value == '0) begin
      push_item.kind = ddf_pkg::KIND_ZERO;
    end else begin
      push_item.kind = ddf_pkg::KIND_POS;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ddf_queue.sv
// Short queue of classified values between front and back end.
`default_nettype none
module ddf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ddf_pkg::item_t   push_item,
  input  logic             pop,
  output ddf_pkg::item_t   pop_item,
  output ddf_pkg::q_stat_t q_stat
);

  ddf_pkg::item_t               slot_r [ddf_pkg::QDEPTH];
  logic [ddf_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [ddf_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [ddf_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign q_stat.full  = (count_r == ddf_pkg::QCNT_W'(ddf_pkg::QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_item     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == ddf_pkg::QPTR_W'(ddf_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == ddf_pkg::QPTR_W'(ddf_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ddf_back.sv
// Back end: emits one digit write per cycle, dividing by ten each step.
`default_nettype none
`include "decimal_display_digit_formatter_assert.svh"
module ddf_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ddf_pkg::q_stat_t            q_stat,
  input  ddf_pkg::item_t              pop_item,
  output logic                        pop,
  output logic                        strobe,
  output logic [ddf_pkg::POS_W-1:0]   out_digit_position,
  output logic [ddf_pkg::CODE_W-1:0]  out_digit_code,
  output logic                        out_last_digit
);

  logic                        active_r, active_nxt;
  logic [ddf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  ddf_pkg::kind_t              kind_r, kind_nxt;
  logic [ddf_pkg::MAG_W-1:0]   mag_r, mag_nxt;

  logic [ddf_pkg::PROD_W-1:0]  prod;
  logic [ddf_pkg::MAG_W-1:0]   quot;
  logic [ddf_pkg::MAG_W-1:0]   rem;
  logic                        last;

  assign prod = ddf_pkg::PROD_W'(mag_r) * ddf_pkg::PROD_W'(ddf_pkg::RECIP);
  assign quot = ddf_pkg::MAG_W'(prod >> ddf_pkg::RECIP_SHIFT);
  assign rem  = mag_r - ((quot << 3) + (quot << 1));

  assign last = active_r && (pos_r == ddf_pkg::POS_W'(ddf_pkg::DIGIT_COUNT));
  assign pop  = !q_stat.empty && (!active_r || last);

  assign strobe             = active_r;
  assign out_digit_position = pos_r;
  assign out_last_digit     = last;

  always_comb begin
    unique case (kind_r)
      ddf_pkg::KIND_NEG: begin
        if (pos_r == ddf_pkg::POS_W'(1)) begin
          out_digit_code = ddf_pkg::CODE_ONE;
        end else if (pos_r == ddf_pkg::POS_W'(2)) begin
          out_digit_code = ddf_pkg::CODE_MINUS;
        end else begin
          out_digit_code = ddf_pkg::CODE_BLANK;
        end
      end
      ddf_pkg::KIND_ZERO: begin
        out_digit_code = (pos_r == ddf_pkg::POS_W'(1)) ? ddf_pkg::CODE_ZERO :
                         ddf_pkg::CODE_BLANK;
      end
      ddf_pkg::KIND_POS: begin
        out_digit_code = (mag_r == '0) ? ddf_pkg::CODE_BLANK :
                         rem[ddf_pkg::CODE_W-1:0];
      end
      default: begin
        out_digit_code = ddf_pkg::CODE_BLANK;
      end
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    mag_nxt    = mag_r;
    if (pop) begin
      active_nxt = 1'b1;
      pos_nxt    = ddf_pkg::POS_W'(1);
      kind_nxt   = pop_item.kind;
      mag_nxt    = pop_item.mag;
    end else if (last) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      mag_nxt = quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r    <= ddf_pkg::POS_W'(1);
      kind_r   <= ddf_pkg::KIND_ZERO;
    end else begin
      active_r <= active_nxt;
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
  end

  `DDF_ASSERT(a_pos_range, clk, rst_n, !strobe || ((out_digit_position != '0) && (out_digit_position <= ddf_pkg::POS_W'(ddf_pkg::DIGIT_COUNT))))
  `DDF_ASSERT_NEXT(a_pop_starts, clk, rst_n, pop, strobe && (out_digit_position == ddf_pkg::POS_W'(1)))
  `DDF_ASSERT_NEXT(a_burst_runs, clk, rst_n, strobe && !out_last_digit, strobe && (out_digit_position == $past(out_digit_position) + 1'b1))
  `DDF_ASSERT(a_neg_codes, clk, rst_n, !(strobe && (kind_r == ddf_pkg::KIND_NEG)) || (out_digit_code == ddf_pkg::CODE_ONE) || (out_digit_code == ddf_pkg::CODE_MINUS) || (out_digit_code == ddf_pkg::CODE_BLANK))

endmodule
`default_nettype wire

>>> rtl/decimal_display_digit_formatter.sv
// Top level of the decimal display digit formatter.
//
// Turns a signed 32-bit value into eight digit-register writes for a Code-B
// seven-segment driver, digit 1 (least significant) first.
// Input: a value beat is taken at a rising edge where start is high and busy
//   is low; in_value carries the number. busy rises only when the queue
//   between front and back end is full.
// Output: each digit write is a beat shown for one cycle with strobe high,
//   carrying out_digit_position (1..8), out_digit_code (0-9, 10 minus,
//   15 blank) and out_last_digit on the eighth write.
// Path: a taken value is written into the queue and then popped into the
//   back-end registers, which drive its digit beats in order.
// Throughput: the back end produces one digit per cycle through its
//   divide-by-ten step, and bursts of successive queued values follow each
//   other with no gap.
// Negative values show "-1", zero shows a single 0, positive values are shown
//   modulo 10^8 with leading zeros blanked.
// Reset (rst_n low, synchronous) empties the queue and drops any burst in
//   flight. The receiver cannot stall: every strobe cycle is a taken beat.
`default_nettype none
module decimal_display_digit_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ddf_pkg::VALUE_W-1:0] in_value,
  output logic                        strobe,
  output logic [ddf_pkg::POS_W-1:0]   out_digit_position,
  output logic [ddf_pkg::CODE_W-1:0]  out_digit_code,
  output logic                        out_last_digit
);

  ddf_pkg::q_stat_t q_stat;
  ddf_pkg::item_t   push_item;
  ddf_pkg::item_t   pop_item;
  logic             push;
  logic             pop;

  // Classify the incoming beat and queue it
  ddf_front u_front (
    .start     (start),
    .in_value  (in_value),
    .q_stat    (q_stat),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  // Hold classified values until the back end is ready for them
  ddf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Advance one digit per cycle and emit the writes
  ddf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .pop_item           (pop_item),
    .pop                (pop),
    .strobe             (strobe),
    .out_digit_position (out_digit_position),
    .out_digit_code     (out_digit_code),
    .out_last_digit     (out_last_digit)
  );

endmodule
`default_nettype wire

>>> sim/decimal_display_digit_formatter_tb.sv
// Self-checking testbench for the decimal display digit formatter.
module decimal_display_digit_formatter_tb;
  import ddf_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_VALUES = 430;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CODE_W-1:0] code;
    logic              last;
  } digit_write_t;

  // Predict the digit writes of each taken value and match them in order.
  class digit_scoreboard;
    digit_write_t pending_writes[$];
    int errors;
    int digits_checked;

    function new();
      errors = 0;
      digits_checked = 0;
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      digit_write_t w;
      int unsigned rest;
      logic [CODE_W-1:0] c;
      rest = v;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        if (v[VALUE_W-1]) begin
          c = (k == 0) ? CODE_ONE : (k == 1) ? CODE_MINUS : CODE_BLANK;
        end else if (v == '0) begin
          c = (k == 0) ? CODE_ZERO : CODE_BLANK;
        end else if (rest == 0) begin
          c = CODE_BLANK;
        end else begin
          c = CODE_W'(rest % 10);
          rest = rest / 10;
        end
        w.pos = POS_W'(k + 1);
        w.code = c;
        w.last = (k == DIGIT_COUNT - 1);
        pending_writes.push_back(w);
      end
    endfunction

    function void check_digit(logic [POS_W-1:0] pos, logic [CODE_W-1:0] code, logic last);
      digit_write_t w;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected digit write pos=%0d code=%0d last=%0b",
                 $time, pos, code, last);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      digits_checked++;
      if (pos !== w.pos) begin
        $display("%0t: digit position expected %0d actual %0d", $time, w.pos, pos);
        errors++;
      end
      if (code !== w.code) begin
        $display("%0t: digit code at pos %0d expected %0d actual %0d",
                 $time, w.pos, w.code, code);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: last digit at pos %0d expected %0b actual %0b",
                 $time, w.pos, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                busy;
  logic                strobe;
  logic [POS_W-1:0]    out_digit_position;
  logic [CODE_W-1:0]   out_digit_code;
  logic                out_last_digit;

  digit_scoreboard sb = new();
  int idle_cycles = 0;
  int values_sent = 0;
  int negatives_sent = 0;
  int truncated_sent = 0;

  decimal_display_digit_formatter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .strobe             (strobe),
    .out_digit_position (out_digit_position),
    .out_digit_code     (out_digit_code),
    .out_last_digit     (out_last_digit)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Monitor both channels at the edge: read pre-edge values, so a taken value
  // beat is start high with busy low, and every strobe cycle is a digit beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) begin
        sb.note_value(in_value);
      end
      if (strobe) begin
        sb.check_digit(out_digit_position, out_digit_code, out_last_digit);
      end
      if ((start && !busy) || strobe) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      // Drop out if neither side has moved a beat for far too long.
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one value beat after an idle gap; hold start high across
  // back-to-back beats so it never toggles within one edge.
  task automatic send_value(input logic [VALUE_W-1:0] v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    values_sent++;
    if (v[VALUE_W-1]) negatives_sent++;
    else if (v >= 100000000) truncated_sent++;
  endtask

  // Pick a positive value with a chosen number of decimal digits, 1 to 10.
  function automatic logic [VALUE_W-1:0] value_of_length(int len);
    longint lo;
    longint hi;
    lo = 1;
    for (int i = 1; i < len; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (len == 1) lo = 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    return VALUE_W'($urandom_range(int'(hi), int'(lo)));
  endfunction

  initial begin
    logic [VALUE_W-1:0] directed[$];
    logic [VALUE_W-1:0] v;
    int gap;
    int pick;
    bit no_idle;

    // Hold reset from time zero, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero, digit lengths, truncation edges and negatives.
    directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd10203040,
                 32'd1234567, 32'd12345678, 32'd99999999, 32'd100000000,
                 32'd100000001, 32'd1000000000, 32'd2147483647, 32'hFFFF_FFFF,
                 32'h8000_0000, -32'sd5, -32'sd1000, 32'd5, 32'd0, 32'd7, 32'hAAAA_AAAA,
                 32'h5555_5555};
    foreach (directed[i]) begin
      send_value(directed[i], (i < 12) ? $urandom_range(0, 5) : 0);
    end

    // Random part: mostly positives of spread digit lengths, plus raw words,
    // negatives and zero. Alternate stretches with and without gaps.
    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_VALUES; n++) begin
      if (n % 40 == 0) no_idle = ~no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 50) v = value_of_length($urandom_range(1, 10));
      else if (pick < 80) v = $urandom;
      else if (pick < 95) v = {1'b1, 31'($urandom)};
      else v = '0;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      send_value(v, gap);
    end
    start <= 1'b0;

    // Drain: wait for every predicted digit, then let the pipe settle.
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_writes.size() != 0) begin
      $display("%0d digit writes never arrived", sb.pending_writes.size());
      sb.errors++;
    end
    $display("covered %0d values (%0d negative, %0d above eight digits), %0d digits checked",
             values_sent, negatives_sent, truncated_sent, sb.digits_checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
